FILE: src/ths_pkg.sv
// shared types and constants for the timeout heap scheduler
// depends on nothing
`timescale 1ns / 1ps
package ths_pkg;
   localparam int NUM_TIMERS_DEF = 32;
   localparam int ID_W = 5;
   localparam int ID_COUNT = 32;

   typedef enum logic [1:0] {
      REQ_ADD = 2'd0,
      REQ_CANCEL = 2'd1,
      REQ_TICK = 2'd2,
      REQ_NONE = 2'd3
   } req_type_type;

   typedef enum logic [2:0] {
      KIND_DONE = 3'd0,
      KIND_EXPIRED = 3'd1,
      KIND_FULL = 3'd2,
      KIND_QUEUED = 3'd3,
      KIND_NOT_QUEUED = 3'd4
   } kind_type;

   typedef struct packed {
      logic [1:0] req;
      logic [ID_W-1:0] id;
      logic [31:0] timeout;
      logic [63:0] now;
   } item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_DEL_RD,
      ST_DOWN_RD,
      ST_DOWN_CMP,
      ST_TICK_RD,
      ST_TICK_CMP
   } state_type;
endpackage

FILE: src/ths_front.sv
// front part: takes command items into a small queue
// depends on ths_pkg
`timescale 1ns / 1ps
module ths_front (
   input logic clock,
   input logic reset,
   input logic push,
   input ths_pkg::item_type push_item,
   input logic pop,
   output logic full,
   output logic not_empty,
   output ths_pkg::item_type head
);
   ths_pkg::item_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic rd_ff, rd_in, wr_ff, wr_in;

   assign full = cnt_ff == 2'd2;
   assign not_empty = cnt_ff != 2'd0;
   assign head = q_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      rd_in = rd_ff ^ pop;
      wr_in = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff <= rd_in;
         wr_ff <= wr_in;
      end
      if (push) q_ff[wr_ff] <= push_item;
   end
endmodule

FILE: src/ths_back.sv
// back part: heap walk over slot memories, emits results
// depends on ths_pkg
`timescale 1ns / 1ps
module ths_back #(
   parameter int NUM_TIMERS = ths_pkg::NUM_TIMERS_DEF
) (
   input logic clock,
   input logic reset,
   input logic have_item,
   input ths_pkg::item_type item,
   output logic take,
   output logic rsp_valid,
   output logic [2:0] rsp_result_kind,
   output logic [4:0] rsp_expired_id,
   output logic rsp_last_of_run
);
   localparam int PW = $clog2(NUM_TIMERS + 1);
   localparam int IW = ths_pkg::ID_W;
   localparam logic [PW-1:0] NT = PW'(NUM_TIMERS);
   localparam logic [PW-1:0] ROOT = PW'(1);

   ths_pkg::state_type st_ff, st_in;
   // heap memory, slots from 1
   logic [63:0] due_mem [NUM_TIMERS+1];
   logic [IW-1:0] own_mem [NUM_TIMERS+1];
   logic [PW-1:0] pos_mem [ths_pkg::ID_COUNT];
   logic [ths_pkg::ID_COUNT-1:0] queued_ff, queued_in;
   logic [PW-1:0] count_ff, count_in;
   logic [63:0] clk_ff, clk_in;

   ths_pkg::item_type cur_ff, cur_in;
   logic [63:0] due_ff, due_in;       // carried entry
   logic [IW-1:0] id_ff, id_in;
   logic [PW-1:0] idx_ff, idx_in;     // current slot
   logic [PW-1:0] tgt_ff, tgt_in;     // insert target
   logic [PW-1:0] lvl_ff, lvl_in;     // bit index along path
   logic pend_ff, pend_in;            // expired id held until the next check
   logic [IW-1:0] pend_id_ff, pend_id_in;
   // registered memory reads
   logic [63:0] rda_ff, rdb_ff;
   logic [IW-1:0] ria_ff, rib_ff;
   logic [PW-1:0] rpos_ff;
   logic [PW-1:0] ra, rb;
   logic we;
   logic [PW-1:0] wa;
   logic [63:0] wd;
   logic [IW-1:0] wi;
   ths_pkg::kind_type kind;
   logic [IW-1:0] oid;
   logic ov, olast;
   // decisions shared by next state and datapath
   logic add_hit, add_full, cancel_bad, in_tick, for_add, del_same, expire;
   logic [PW-1:0] tgt_sh;
   logic [PW:0] l_ext, r_ext;
   logic r_ok, down_leaf, pick_right, move_down;
   logic [PW-1:0] c_pos;
   logic [63:0] c_due;
   logic [IW-1:0] c_id;

   function automatic logic [PW-1:0] top_bit(input logic [PW-1:0] v);
      logic [PW-1:0] r;
      r = '0;
      for (int k = 0; k < PW; k++) if (v[k]) r = PW'(k);
      return r;
   endfunction

   assign add_hit = queued_ff[cur_ff.id];
   assign add_full = count_ff >= NT;
   assign cancel_bad = !queued_ff[cur_ff.id] || rpos_ff < ROOT || rpos_ff > count_ff;
   assign in_tick = cur_ff.req == ths_pkg::REQ_TICK;
   assign for_add = cur_ff.req == ths_pkg::REQ_ADD;
   assign del_same = count_ff == tgt_ff;
   assign expire = count_ff != '0 && rda_ff <= clk_ff;
   assign tgt_sh = tgt_ff >> (lvl_ff - 1'b1);
   assign l_ext = {idx_ff, 1'b0};
   assign r_ext = l_ext + 1'b1;
   assign down_leaf = l_ext > {1'b0, count_ff};
   assign r_ok = r_ext <= {1'b0, count_ff};
   // left child wins when strictly earlier or when there is no right child
   assign pick_right = r_ok && !(rda_ff < rdb_ff);
   assign c_pos = pick_right ? r_ext[PW-1:0] : l_ext[PW-1:0];
   assign c_due = pick_right ? rdb_ff : rda_ff;
   assign c_id = pick_right ? rib_ff : ria_ff;
   assign move_down = due_ff > c_due;

   always_ff @(posedge clock) begin
      rda_ff <= due_mem[ra];
      ria_ff <= own_mem[ra];
      rdb_ff <= due_mem[rb];
      rib_ff <= own_mem[rb];
      rpos_ff <= pos_mem[cur_in.id];
      if (we) begin
         due_mem[wa] <= wd;
         own_mem[wa] <= wi;
         pos_mem[wi] <= wa;
      end
   end

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ths_pkg::ST_IDLE: if (have_item) st_in = ths_pkg::ST_DECODE;
         ths_pkg::ST_DECODE: begin
            case (cur_ff.req)
               ths_pkg::REQ_ADD: begin
                  if (add_hit || add_full) st_in = ths_pkg::ST_IDLE;
                  else if (count_ff == '0) st_in = ths_pkg::ST_INS_PUT;
                  else st_in = ths_pkg::ST_INS_RD;
               end
               ths_pkg::REQ_CANCEL:
                  st_in = cancel_bad ? ths_pkg::ST_IDLE : ths_pkg::ST_DEL_RD;
               ths_pkg::REQ_TICK: st_in = ths_pkg::ST_TICK_RD;
               default: st_in = ths_pkg::ST_IDLE;
            endcase
         end
         ths_pkg::ST_INS_RD: st_in = ths_pkg::ST_INS_CMP;
         ths_pkg::ST_INS_CMP:
            st_in = (lvl_ff == ROOT) ? ths_pkg::ST_INS_PUT : ths_pkg::ST_INS_RD;
         ths_pkg::ST_INS_PUT:
            st_in = for_add ? ths_pkg::ST_IDLE : ths_pkg::ST_DOWN_RD;
         ths_pkg::ST_DEL_RD: begin
            if (del_same) st_in = in_tick ? ths_pkg::ST_TICK_RD : ths_pkg::ST_IDLE;
            else if (tgt_ff == ROOT) st_in = ths_pkg::ST_INS_PUT;
            else st_in = ths_pkg::ST_INS_RD;
         end
         ths_pkg::ST_DOWN_RD: begin
            if (down_leaf) st_in = in_tick ? ths_pkg::ST_TICK_RD : ths_pkg::ST_IDLE;
            else st_in = ths_pkg::ST_DOWN_CMP;
         end
         ths_pkg::ST_DOWN_CMP: begin
            if (move_down) st_in = ths_pkg::ST_DOWN_RD;
            else st_in = in_tick ? ths_pkg::ST_TICK_RD : ths_pkg::ST_IDLE;
         end
         ths_pkg::ST_TICK_RD: st_in = ths_pkg::ST_TICK_CMP;
         ths_pkg::ST_TICK_CMP: st_in = expire ? ths_pkg::ST_DEL_RD : ths_pkg::ST_IDLE;
         default: st_in = ths_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cur_in = cur_ff; due_in = due_ff; id_in = id_ff; idx_in = idx_ff;
      tgt_in = tgt_ff; lvl_in = lvl_ff; pend_in = pend_ff; pend_id_in = pend_id_ff;
      queued_in = queued_ff; count_in = count_ff; clk_in = clk_ff;
      ra = idx_ff; rb = idx_ff; we = 1'b0; wa = idx_ff; wd = due_ff; wi = id_ff;
      kind = ths_pkg::KIND_DONE; oid = '0; ov = 1'b0; olast = 1'b1;
      take = 1'b0;
      case (st_ff)
         ths_pkg::ST_IDLE: begin
            if (have_item) begin
               take = 1'b1;
               cur_in = item;
            end
         end
         ths_pkg::ST_DECODE: begin
            case (cur_ff.req)
               ths_pkg::REQ_ADD: begin
                  if (add_hit) begin
                     ov = 1'b1; kind = ths_pkg::KIND_QUEUED;
                  end else if (add_full) begin
                     ov = 1'b1; kind = ths_pkg::KIND_FULL;
                  end else begin
                     queued_in[cur_ff.id] = 1'b1;
                     count_in = count_ff + 1'b1;
                     tgt_in = count_ff + 1'b1;
                     due_in = clk_ff + {32'd0, cur_ff.timeout};
                     id_in = cur_ff.id;
                     idx_in = ROOT;
                     lvl_in = top_bit(count_ff + 1'b1);
                  end
               end
               ths_pkg::REQ_CANCEL: begin
                  if (cancel_bad) begin
                     ov = 1'b1; kind = ths_pkg::KIND_NOT_QUEUED;
                  end else begin
                     queued_in[cur_ff.id] = 1'b0;
                     tgt_in = rpos_ff;
                     ra = count_ff;
                  end
               end
               ths_pkg::REQ_TICK: begin
                  clk_in = cur_ff.now;
                  pend_in = 1'b0;
               end
               default: begin
                  ov = 1'b1; kind = ths_pkg::KIND_DONE;
               end
            endcase
         end
         ths_pkg::ST_INS_RD: ra = idx_ff;
         ths_pkg::ST_INS_CMP: begin
            // earlier entry stays, the later one travels down the path
            if (due_ff < rda_ff) begin
               we = 1'b1; wa = idx_ff;
               due_in = rda_ff; id_in = ria_ff;
            end
            idx_in = {idx_ff[PW-2:0], tgt_sh[0]};
            lvl_in = lvl_ff - 1'b1;
         end
         ths_pkg::ST_INS_PUT: begin
            we = 1'b1; wa = tgt_ff;
            if (for_add) ov = 1'b1;
         end
         ths_pkg::ST_DEL_RD: begin
            // last entry read, shrink heap
            count_in = count_ff - 1'b1;
            if (del_same) begin
               if (!in_tick) ov = 1'b1;
            end else begin
               due_in = rda_ff; id_in = ria_ff;
               idx_in = ROOT;
               lvl_in = top_bit(tgt_ff);
            end
         end
         ths_pkg::ST_DOWN_RD: begin
            if (down_leaf) begin
               we = 1'b1; wa = idx_ff;
               if (!in_tick) ov = 1'b1;
            end else begin
               ra = l_ext[PW-1:0];
               rb = r_ok ? r_ext[PW-1:0] : l_ext[PW-1:0];
            end
         end
         ths_pkg::ST_DOWN_CMP: begin
            // the carried entry is written only once it settles
            if (move_down) begin
               we = 1'b1; wa = idx_ff; wd = c_due; wi = c_id;
               idx_in = c_pos;
            end else begin
               we = 1'b1; wa = idx_ff;
               if (!in_tick) ov = 1'b1;
            end
         end
         ths_pkg::ST_TICK_RD: ra = ROOT;
         ths_pkg::ST_TICK_CMP: begin
            if (expire) begin
               queued_in[ria_ff] = 1'b0;
               if (pend_ff) begin
                  ov = 1'b1; kind = ths_pkg::KIND_EXPIRED; oid = pend_id_ff; olast = 1'b0;
               end
               pend_in = 1'b1;
               pend_id_in = ria_ff;
               tgt_in = ROOT;
               ra = count_ff;
            end else begin
               ov = 1'b1;
               if (pend_ff) begin
                  kind = ths_pkg::KIND_EXPIRED; oid = pend_id_ff;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ths_pkg::ST_IDLE;
         queued_ff <= '0;
         count_ff <= '0;
         clk_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         st_ff <= st_in;
         queued_ff <= queued_in;
         count_ff <= count_in;
         clk_ff <= clk_in;
         pend_ff <= pend_in;
         rsp_valid <= ov;
      end
      cur_ff <= cur_in; due_ff <= due_in;
      id_ff <= id_in; idx_ff <= idx_in; tgt_ff <= tgt_in;
      lvl_ff <= lvl_in; pend_id_ff <= pend_id_in;
      rsp_result_kind <= kind;
      rsp_expired_id <= oid;
      rsp_last_of_run <= olast;
   end
endmodule

FILE: src/timeout_heap_scheduler_core.sv
// top level of the timeout heap scheduler: front queue and heap back end
// depends on ths_pkg, ths_front, ths_back
`timescale 1ns / 1ps
// An item waits in a two-entry command queue; busy stays high while that queue is
// full. The back end answers a rejected add, a cancel of an idle timer or an unused
// code without walking the heap. An add walks the path from the root to the new
// slot, a cancel of the last slot just shrinks the heap, any other cancel walks to
// the freed slot and sifts below it, and a tick sifts once for each expired timer;
// the heap walk runs over slot memories with registered reads. Results come one
// per strobe on rsp_valid and cannot be held off. A tick reports every expired id
// in pop order with last_of_run on the final one; an add, a cancel or a tick with
// nothing due gives one result with last_of_run set.
module timeout_heap_scheduler_core #(
   parameter int NUM_TIMERS = ths_pkg::NUM_TIMERS_DEF
) (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input logic [1:0] req_type,
   input logic [4:0] req_timer_id,
   input logic [31:0] req_timeout,
   input logic [63:0] req_now_time,
   output logic rsp_valid,
   output logic [2:0] rsp_result_kind,
   output logic [4:0] rsp_expired_id,
   output logic rsp_last_of_run
);
   ths_pkg::item_type in_item, head;
   logic full, not_empty, take;

   assign in_item = '{req: req_type, id: req_timer_id, timeout: req_timeout,
                      now: req_now_time};
   assign busy = full;

   ths_front u_front (
      .clock(clock), .reset(reset), .push(start && !full), .push_item(in_item),
      .pop(take), .full(full), .not_empty(not_empty), .head(head)
   );

   ths_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
      .clock(clock), .reset(reset), .have_item(not_empty), .item(head),
      .take(take), .rsp_valid(rsp_valid),
      .rsp_result_kind(rsp_result_kind), .rsp_expired_id(rsp_expired_id),
      .rsp_last_of_run(rsp_last_of_run)
   );
endmodule

FILE: src/ths_checker.sv
// port-level checks for the timeout heap scheduler
// depends on timeout_heap_scheduler_core ports and ths_pkg
`timescale 1ns / 1ps
module ths_checker (
   input logic clock,
   input logic reset,
   input logic busy,
   input logic rsp_valid,
   input logic [2:0] rsp_result_kind,
   input logic [4:0] rsp_expired_id
);
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_result_kind <= ths_pkg::KIND_NOT_QUEUED) else $error("bad kind");
   a_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != ths_pkg::KIND_EXPIRED |-> rsp_expired_id == 5'd0)
      else $error("id on non-expiry");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_valid && !busy)
      else $error("reset");
endmodule

bind timeout_heap_scheduler_core ths_checker u_chk (
   .clock(clock), .reset(reset), .busy(busy), .rsp_valid(rsp_valid),
   .rsp_result_kind(rsp_result_kind), .rsp_expired_id(rsp_expired_id)
);
